[src/mie_pkg.sv]
package mie_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOINV    = 2'd1;
	localparam status_t ST_MOD_ZERO = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_CHECK,
		S_STEP,
		S_FINISH
	} state_t;

endpackage

[src/mie_in_if.sv]
interface mie_in_if #(parameter int WIDTH = 64);
	logic               valid;
	logic               ready;
	logic [WIDTH-1:0]   value;
	logic [WIDTH-2:0]   modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink   (input valid, input value, input modulus, output ready);
endinterface

[src/mie_out_if.sv]
interface mie_out_if #(parameter int WIDTH = 64);
	logic               valid;
	logic               ready;
	logic [WIDTH-2:0]   inverse;
	logic [WIDTH-2:0]   common_divisor;
	mie_pkg::status_t   status;

	modport source (output valid, output inverse, output common_divisor, output status,
		input ready);
	modport sink   (input valid, input inverse, input common_divisor, input status,
		output ready);
endinterface

[src/modular_inverse_extended_gcd.sv]
// Modular inverse by the extended Euclidean algorithm. Each beat on operand carries a signed
// value and a modulus; the block reduces the value into [0, modulus) and runs Euclid, giving
// one beat on result with the gcd and, when the gcd is 1, the inverse in [0, modulus). A zero
// modulus gives status 2 and zero fields. All divisions go through one restoring divider
// that retires one quotient bit per cycle and builds the coefficient product alongside:
// one division for the reduction and one for every Euclid step. For 64-bit operands Euclid
// needs at most about 92 steps. Operand ready is high only while no item is in work; a
// finished result waits in the output register without holding up the next input.
module modular_inverse_extended_gcd #(
	parameter int WIDTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	mie_in_if.sink     operand,
	mie_out_if.source  result
);
	import mie_pkg::*;

	localparam int M = WIDTH - 1;

	state_t state_q, state_d;

	logic [M-1:0]     m_q;
	logic [M-1:0]     u_q;
	logic [M-1:0]     v_q;
	logic [M-1:0]     s_u_q;
	logic [M-1:0]     s_v_q;
	logic             odd_q;
	logic             neg_q;
	logic             zero_q;

	logic             out_valid_q;
	logic [M-1:0]     inv_q;
	logic [M-1:0]     gcd_q;
	status_t          status_q;

	logic             accept;
	logic             out_load;
	logic             div_start;
	logic [WIDTH-1:0] div_dividend;
	logic [M-1:0]     div_divisor;
	logic [M-1:0]     div_mult;
	logic             div_done;
	logic [M-1:0]     div_rem;
	logic [M-1:0]     div_prod;

	logic [WIDTH-1:0] mag_c;
	logic [M-1:0]     red_c;
	logic [M-1:0]     inv_base_c;
	logic [M-1:0]     inv_c;

	mie_div #(.WIDTH(WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.mult     (div_mult),
		.done     (div_done),
		.rem      (div_rem),
		.prod     (div_prod)
	);

	always_comb begin
		mag_c      = operand.value[WIDTH-1] ? -operand.value : operand.value;
		red_c      = (neg_q && div_rem != '0) ? m_q - div_rem : div_rem;
		inv_base_c = (s_u_q == m_q) ? '0 : s_u_q;
		inv_c      = (odd_q && inv_base_c != '0) ? m_q - inv_base_c : inv_base_c;
	end

	always_comb begin
		if (state_q == S_CHECK) begin
			div_dividend = {1'b0, u_q};
			div_divisor  = v_q;
			div_mult     = s_v_q;
		end else begin
			div_dividend = mag_c;
			div_divisor  = operand.modulus;
			div_mult     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		operand.ready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		accept        = 1'b0;
		case (state_q)
			S_IDLE: begin
				operand.ready = 1'b1;
				if (operand.valid) begin
					accept = 1'b1;
					if (operand.modulus == '0) begin
						state_d = S_FINISH;
					end else begin
						div_start = 1'b1;
						state_d   = S_REDUCE;
					end
				end
			end
			S_REDUCE: begin
				if (div_done)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (v_q == '0) begin
					state_d = S_FINISH;
				end else begin
					div_start = 1'b1;
					state_d   = S_STEP;
				end
			end
			S_STEP: begin
				if (div_done)
					state_d = S_CHECK;
			end
			S_FINISH: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_q    <= operand.modulus;
			neg_q  <= operand.value[WIDTH-1];
			zero_q <= operand.modulus == '0;
		end
		if (state_q == S_REDUCE && div_done) begin
			u_q   <= red_c;
			v_q   <= m_q;
			s_u_q <= M'(1);
			s_v_q <= '0;
			odd_q <= 1'b0;
		end
		if (state_q == S_STEP && div_done) begin
			u_q   <= v_q;
			v_q   <= div_rem;
			s_u_q <= s_v_q;
			s_v_q <= s_u_q + div_prod;
			odd_q <= !odd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (zero_q) begin
				inv_q    <= '0;
				gcd_q    <= '0;
				status_q <= ST_MOD_ZERO;
			end else if (u_q != M'(1)) begin
				inv_q    <= '0;
				gcd_q    <= u_q;
				status_q <= ST_NOINV;
			end else begin
				inv_q    <= inv_c;
				gcd_q    <= M'(1);
				status_q <= ST_OK;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.inverse        = inv_q;
	assign result.common_divisor = gcd_q;
	assign result.status         = status_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_REDUCE || state_q == S_STEP))
		else $error("divider finished outside a wait state");

	a_inv_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !zero_q && u_q == M'(1)) |-> inv_c < m_q)
		else $error("inverse not below modulus");

	a_load_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("result raised outside finish");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !operand.ready)
		else $error("input ready while divider runs");

endmodule

[src/mie_div.sv]
module mie_div #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-2:0] divisor,
	input  logic [WIDTH-2:0] mult,
	output logic             done,
	output logic [WIDTH-2:0] rem,
	output logic [WIDTH-2:0] prod
);
	localparam int M  = WIDTH - 1;
	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] dvd_q;
	logic [M-1:0]     dvs_q;
	logic [M-1:0]     mul_q;
	logic [WIDTH-1:0] rem_q;
	logic [M-1:0]     acc_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;

	logic [WIDTH-1:0] rem_sh;
	logic             take;
	logic [WIDTH-1:0] rem_nx;
	logic [M-1:0]     acc_nx;

	// one quotient bit per cycle; acc builds quotient * mult by shift-and-add
	always_comb begin
		rem_sh = {rem_q[WIDTH-2:0], dvd_q[WIDTH-1]};
		take   = rem_sh >= {1'b0, dvs_q};
		rem_nx = take ? rem_sh - {1'b0, dvs_q} : rem_sh;
		acc_nx = {acc_q[M-2:0], 1'b0} + (take ? mul_q : {M{1'b0}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			mul_q <= mult;
			rem_q <= '0;
			acc_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_nx;
			acc_q <= acc_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[M-1:0];
	assign prod = acc_q;

endmodule
